// ----- hw/rtl/bre_pkg.sv -----
// ----------------------------------------------------------------------------
// bre_pkg
// shared widths, command codes and state type of the bitmap range engine
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 13;
  localparam int WORD_W  = 64;
  localparam int POS_W   = 6;
  localparam int PC_W    = 7;
  localparam int IDX_SPAN = 4096;
  localparam logic [VAL_W-1:0] SIZE_RESET = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_FIND  = 2'd3
  } bre_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } bre_state_t;

endpackage

// ----- hw/rtl/bre_ifs.sv -----
// ----------------------------------------------------------------------------
// bre interfaces
// request, response and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bre_req_if;
  logic                         valid;
  logic                         ready;
  logic [bre_pkg::CMD_W-1:0]    command;
  logic [bre_pkg::IDX_W-1:0]    bit_index;
  logic [bre_pkg::IDX_W-1:0]    range_end;
  logic                         bit_value;

  modport source (output valid, command, bit_index, range_end, bit_value, input ready);
  modport sink (input valid, command, bit_index, range_end, bit_value, output ready);
endinterface

interface bre_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bre_pkg::VAL_W-1:0]    value;
  logic                         found;
  logic                         error;

  modport source (output valid, value, found, error, input ready);
  modport sink (input valid, value, found, error, output ready);
endinterface

interface bre_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bre_pkg::VAL_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/bre_ram.sv -----
// ----------------------------------------------------------------------------
// bre_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bitmap_range_engine.sv -----
// ----------------------------------------------------------------------------
// bitmap_range_engine
// bit store with get, set, range count and range find-first-set commands
// ----------------------------------------------------------------------------
// usage:
//   req carries one command word (command, bit_index, range_end, bit_value);
//   rsp returns exactly one word (value, found, error) per command, in order.
//   cfg writes the size register (size_bits); write it only while idle.
// datapath and flow:
//   the store is 64-bit words in a ram with a registered read. get and set
//   work on one word. count and find scan one word per cycle from the start
//   word to the end word; a find stops at the first word holding a set bit.
//   a command with an error skips the scan. one command is in work at a
//   time; req is ready again once the result has moved to the response
//   register.
// reset:
//   the store reads as all zeros through per-word valid flags, size_bits
//   returns to 4096, no clearing pass is needed.
// stall:
//   a waiting response holds; the next command may still be accepted and
//   worked on, and it waits for the response register before finishing.
// ----------------------------------------------------------------------------
module bitmap_range_engine #(
  parameter int MAX_BITS = 4096
) (
  input  logic     clk,
  input  logic     rst,
  bre_cfg_if.sink  cfg,
  bre_req_if.sink  req,
  bre_rsp_if.source rsp
);
  import bre_pkg::*;

  localparam int REACH    = (MAX_BITS < IDX_SPAN) ? MAX_BITS : IDX_SPAN;
  localparam int WORDS    = (REACH + WORD_W - 1) / WORD_W;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SIZE_CAP = (MAX_BITS < 8191) ? MAX_BITS : 8191;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_W-1:0] w);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + PC_W'(w[i]);
    end
    return n;
  endfunction

  function automatic logic [POS_W-1:0] first_set(input logic [WORD_W-1:0] w);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  bre_state_t         state;
  bre_state_t         state_next;

  logic [VAL_W-1:0]   size_bits;
  logic [VAL_W-1:0]   active_size;

  bre_cmd_t           cmd;
  logic [IDX_W-1:0]   start_idx;
  logic [IDX_W-1:0]   stop_idx;
  logic               bval;
  logic [AW-1:0]      cw;
  logic [VAL_W-1:0]   count;
  logic [VAL_W-1:0]   res_value;
  logic               res_found;
  logic               res_error;
  logic [WORDS-1:0]   word_valid;

  logic [VAL_W-1:0]   out_value;
  logic               out_found;
  logic               out_error;
  logic               out_valid;

  logic               req_fire;
  logic               req_err;
  logic               out_free;
  logic               out_load;

  logic [AW-1:0]      start_w;
  logic [AW-1:0]      stop_w;
  logic [AW-1:0]      req_w;
  logic               is_first;
  logic               is_last;
  logic               single;
  logic               scan_done;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WORD_W-1:0]  word_raw;
  logic [WORD_W-1:0]  word_set;
  logic [WORD_W-1:0]  bit_mask;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  masked;
  logic [PC_W-1:0]    pc;
  logic [POS_W-1:0]   ffs_pos;
  logic               hit;
  logic [VAL_W-1:0]   count_next;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits <= SIZE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      size_bits <= cfg.data;
    end
  end

  assign active_size = (size_bits < VAL_W'(SIZE_CAP)) ? size_bits : VAL_W'(SIZE_CAP);

  // request check
  assign req_fire = req.valid && req.ready;
  assign req_err  = req.command[1]
                  ? ((req.bit_index > req.range_end) ||
                     ({1'b0, req.range_end} >= active_size))
                  : ({1'b0, req.bit_index} >= active_size);
  assign req_w    = req.bit_index[AW+POS_W-1:POS_W];

  // word scan datapath
  assign start_w  = start_idx[AW+POS_W-1:POS_W];
  assign stop_w   = stop_idx[AW+POS_W-1:POS_W];
  assign is_first = (cw == start_w);
  assign is_last  = (cw == stop_w);
  assign single   = (cmd == CMD_GET) || (cmd == CMD_SET);

  assign word_raw = word_valid[cw] ? ram_rdata : '0;
  assign bit_mask = WORD_W'(1) << start_idx[POS_W-1:0];
  assign word_set = bval ? (word_raw | bit_mask) : (word_raw & ~bit_mask);
  assign lo_mask  = is_first ? ({WORD_W{1'b1}} << start_idx[POS_W-1:0]) : {WORD_W{1'b1}};
  assign hi_mask  = is_last ? ({WORD_W{1'b1}} >> (POS_W'(WORD_W - 1) - stop_idx[POS_W-1:0]))
                            : {WORD_W{1'b1}};
  assign masked   = word_raw & lo_mask & hi_mask;
  assign pc       = popcount(masked);
  assign ffs_pos  = first_set(masked);
  assign hit      = |masked;
  assign count_next = count + VAL_W'(pc);

  assign scan_done = single || is_last || ((cmd == CMD_FIND) && hit);

  assign out_free = !out_valid || rsp.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = req_err ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    ram_raddr = is_last ? cw : cw + AW'(1);
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = req_w;
      end
      ST_SCAN: begin
        ram_we = (cmd == CMD_SET);
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  bre_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cw),
    .wdata (word_set),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-word valid flags, an unwritten word reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (ram_we) begin
      word_valid[cw] <= 1'b1;
    end
  end

  // command registers and result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire) begin
      cmd       <= bre_cmd_t'(req.command);
      start_idx <= req.bit_index;
      stop_idx  <= req.range_end;
      bval      <= req.bit_value;
      cw        <= req_w;
      count     <= '0;
      res_value <= '0;
      res_found <= 1'b0;
      res_error <= req_err;
    end else if (state == ST_SCAN) begin
      case (cmd)
        CMD_GET: begin
          res_value <= VAL_W'(word_raw[start_idx[POS_W-1:0]]);
        end
        CMD_COUNT: begin
          count     <= count_next;
          res_value <= count_next;
        end
        CMD_FIND: begin
          if (hit) begin
            res_value <= VAL_W'({cw, ffs_pos});
            res_found <= 1'b1;
          end
        end
        default: begin
          res_value <= '0;
        end
      endcase
      if (!scan_done) begin
        cw <= cw + AW'(1);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res_value;
      out_found <= res_found;
      out_error <= res_error;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign rsp.found = out_found;
  assign rsp.error = out_error;

endmodule

// ----- hw/rtl/bre_checker.sv -----
// ----------------------------------------------------------------------------
// bre_checker
// port level checks of the bitmap range engine, bound to the top level
// ----------------------------------------------------------------------------
module bre_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [bre_pkg::VAL_W-1:0] rsp_value,
  input logic                      rsp_found,
  input logic                      rsp_error
);

  // stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) &&
                                $stable(rsp_found) && $stable(rsp_error))
    else $error("response word changed under stall");

  // engine busy after taking a command
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_error |-> rsp_value == '0 && !rsp_found)
    else $error("error word carries a value");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> !rsp_error)
    else $error("found and error together");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind bitmap_range_engine bre_checker u_bre_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.value),
  .rsp_found (rsp.found),
  .rsp_error (rsp.error)
);

// ----- verif/bitmap_checker.sv -----
// ----------------------------------------------------------------------------
// bitmap_checker
// watches the cfg, req and rsp channels of the bitmap range engine, keeps its
// own copy of the bit store and size register, works out the word each
// accepted command must return and compares returned words in order
// ----------------------------------------------------------------------------
module bitmap_checker #(
  parameter int MAX_BITS = 4096
) (
  input  logic clk,
  input  logic rst,
  bre_cfg_if   cfg,
  bre_req_if   req,
  bre_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   found_hits,
  output int   error_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  import bre_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             found;
    logic             error;
  } answer_t;

  bit [MAX_BITS-1:0] bitmap;
  logic [VAL_W-1:0]  size_reg;
  answer_t           answers[$];
  int                fails;
  int                n_checked;
  int                n_found;
  int                n_error;

  initial begin
    fails      = 0;
    n_checked  = 0;
    n_found    = 0;
    n_error    = 0;
    bitmap     = '0;
    size_reg   = SIZE_RESET;
  end

  function automatic answer_t bitmap_answer(bre_cmd_t c, int s, int e, logic bv);
    answer_t a;
    int      lim;
    a = '0;
    lim = (int'(size_reg) < MAX_BITS) ? int'(size_reg) : MAX_BITS;
    case (c)
      CMD_GET, CMD_SET: begin
        if (s >= lim) begin
          a.error = 1'b1;
        end else if (c == CMD_GET) begin
          a.value = VAL_W'(bitmap[s]);
        end else begin
          bitmap[s] = bv;
        end
      end
      default: begin
        if (s > e || e >= lim) begin
          a.error = 1'b1;
        end else begin
          for (int i = s; i <= e; i++) begin
            if (bitmap[i]) begin
              if (c == CMD_COUNT) begin
                a.value = a.value + VAL_W'(1);
              end else if (!a.found) begin
                a.value = VAL_W'(i);
                a.found = 1'b1;
              end
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  task report_mismatch(input string what, input int got, input int want);
    fails++;
    if (fails <= 100) begin
      $display("%0t ns: rsp %s got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      bitmap   = '0;
      size_reg = SIZE_RESET;
      answers.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        n_checked++;
        if (rsp.found === 1'b1) n_found++;
        if (rsp.error === 1'b1) n_error++;
        if (answers.size() == 0) begin
          report_mismatch("word with no command waiting, value", int'(rsp.value), -1);
        end else begin
          want = answers.pop_front();
          if (rsp.value !== want.value)
            report_mismatch("value", int'(rsp.value), int'(want.value));
          if (rsp.found !== want.found)
            report_mismatch("found", int'(rsp.found), int'(want.found));
          if (rsp.error !== want.error)
            report_mismatch("error", int'(rsp.error), int'(want.error));
        end
      end
      if (cfg.valid && cfg.ready) begin
        size_reg = cfg.data;
      end
      if (req.valid && req.ready) begin
        answers.push_back(bitmap_answer(bre_cmd_t'(req.command), int'(req.bit_index),
                                        int'(req.range_end), req.bit_value));
      end
    end
    fail_count <= fails;
    pending    <= answers.size();
    checked    <= n_checked;
    found_hits <= n_found;
    error_hits <= n_error;
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives the bitmap range engine with directed and random get, set, count and
// find commands over a series of size settings, with random idling on both
// sides and long response stalls; bitmap_checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bre_pkg::*;

  logic clk = 1'b0;
  logic rst;

  bre_cfg_if cfg_ch ();
  bre_req_if req_ch ();
  bre_rsp_if rsp_ch ();

  int chk_fails;
  int pending;
  int checked;
  int found_hits;
  int error_hits;

  int req_idle_pct;
  int rsp_idle_pct;
  int hold_left = 0;
  int holds_asked;
  int holds_done = 0;
  int n_items;
  int n_cmd[4];
  int n_settings;
  int cur_size;
  int hot_base;

  int phase_size[10]  = '{4096, 8191, 64, 1, 0, 4095, 100, -1, 2048, 4096};
  int phase_items[10] = '{260, 220, 200, 40, 40, 220, 200, 220, 200, 150};

  bitmap_range_engine DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bitmap_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (chk_fails),
    .pending    (pending),
    .checked    (checked),
    .found_hits (found_hits),
    .error_hits (error_hits)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // response side: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_ch.ready  <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done    <= holds_asked;
      hold_left     <= 300;
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  task automatic send_cmd(input bre_cmd_t c, input int s, input int e, input logic bv);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_W'($urandom_range(3));
      req_ch.bit_index <= IDX_W'($urandom_range(IDX_SPAN-1));
      req_ch.range_end <= IDX_W'($urandom_range(IDX_SPAN-1));
      req_ch.bit_value <= 1'($urandom_range(1));
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= c;
    req_ch.bit_index <= IDX_W'(s);
    req_ch.range_end <= IDX_W'(e);
    req_ch.bit_value <= bv;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_items++;
    n_cmd[c]++;
  endtask

  task automatic wait_all_answered();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_size(input int sz);
    wait_all_answered();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= VAL_W'(sz);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_size = sz;
    n_settings++;
  endtask

  function automatic int pick_pos(input int act);
    int p;
    if ($urandom_range(1)) return $urandom_range(act-1);
    p = hot_base + $urandom_range(127);
    if (p >= act) p = $urandom_range(act-1);
    return p;
  endfunction

  task automatic random_cmd();
    int       act;
    int       r;
    int       s;
    int       e;
    bre_cmd_t c;
    logic     bv;
    bit       bad;
    act = (cur_size < IDX_SPAN) ? cur_size : IDX_SPAN;
    r   = $urandom_range(99);
    c   = (r < 35) ? CMD_SET : (r < 55) ? CMD_GET : (r < 75) ? CMD_COUNT : CMD_FIND;
    bv  = ($urandom_range(99) < 70);
    s   = $urandom_range(IDX_SPAN-1);
    e   = $urandom_range(IDX_SPAN-1);
    bad = ($urandom_range(99) < 8);
    if (act == 0) begin
      send_cmd(c, s, e, bv);
      return;
    end
    if (c == CMD_GET || c == CMD_SET) begin
      s = (bad && act < IDX_SPAN) ? $urandom_range(IDX_SPAN-1, act) : pick_pos(act);
    end else begin
      r = $urandom_range(99);
      if (r < 10) begin
        s = 0;
        e = act - 1;
      end else begin
        s = pick_pos(act);
        e = s + ((r < 75) ? $urandom_range(127) : $urandom_range(1023));
        if (e >= act) e = act - 1;
      end
      if (bad) begin
        if (act < IDX_SPAN && $urandom_range(1)) begin
          e = $urandom_range(IDX_SPAN-1, act);
        end else if (s > 0) begin
          e = $urandom_range(s-1);
        end else if (act > 1) begin
          s = $urandom_range(act-1, 1);
          e = 0;
        end else begin
          e = $urandom_range(IDX_SPAN-1, 1);
        end
      end
    end
    send_cmd(c, s, e, bv);
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_GET;
    req_ch.bit_index = '0;
    req_ch.range_end = '0;
    req_ch.bit_value = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    holds_asked      = 0;
    n_items          = 0;
    n_cmd            = '{0, 0, 0, 0};
    n_settings       = 0;
    cur_size         = int'(SIZE_RESET);
    hot_base         = 0;
    req_idle_pct     = 33;
    rsp_idle_pct     = 81;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges of the store, word boundaries, empty finds, bad ranges
    send_cmd(CMD_GET,   0,    0,    1'b0);
    send_cmd(CMD_GET,   4095, 0,    1'b1);
    send_cmd(CMD_SET,   0,    0,    1'b1);
    send_cmd(CMD_SET,   4095, 4095, 1'b1);
    send_cmd(CMD_SET,   63,   0,    1'b1);
    send_cmd(CMD_SET,   64,   0,    1'b1);
    send_cmd(CMD_GET,   0,    0,    1'b0);
    send_cmd(CMD_GET,   4095, 0,    1'b0);
    send_cmd(CMD_COUNT, 0,    4095, 1'b0);
    send_cmd(CMD_COUNT, 1,    62,   1'b1);
    send_cmd(CMD_COUNT, 63,   64,   1'b0);
    send_cmd(CMD_FIND,  0,    4095, 1'b0);
    send_cmd(CMD_FIND,  1,    4095, 1'b0);
    send_cmd(CMD_FIND,  65,   4094, 1'b1);
    send_cmd(CMD_FIND,  4095, 4095, 1'b0);
    send_cmd(CMD_COUNT, 5,    4,    1'b0);
    send_cmd(CMD_FIND,  4095, 0,    1'b0);
    send_cmd(CMD_SET,   63,   0,    1'b0);
    send_cmd(CMD_GET,   63,   0,    1'b0);
    send_cmd(CMD_SET,   2000, 0,    1'b0);
    send_cmd(CMD_FIND,  1,    63,   1'b0);

    foreach (phase_size[p]) begin
      write_size((phase_size[p] < 0) ? $urandom_range(IDX_SPAN-1, 2) : phase_size[p]);
      hot_base = (cur_size > 0) ? $urandom_range(((cur_size < IDX_SPAN) ? cur_size : IDX_SPAN) - 1)
                                : 0;
      for (int k = 0; k < phase_items[p]; k++) begin
        if (n_items < 600) begin
          req_idle_pct = 33;
          rsp_idle_pct = 81;
        end else if (n_items < 1200) begin
          req_idle_pct = 81;
          rsp_idle_pct = 33;
        end else begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
        if ((p == 0 && k == 50) || (p == 9 && k == 30)) holds_asked <= holds_asked + 1;
        if (p == 5 && k == 110) wait_all_answered();
        random_cmd();
      end
    end

    req_ch.valid <= 1'b0;
    for (int w = 0; w < 50000 && pending != 0; w++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);

    $display("sent %0d commands (get %0d, set %0d, count %0d, find %0d) under %0d size settings",
             n_items, n_cmd[CMD_GET], n_cmd[CMD_SET], n_cmd[CMD_COUNT], n_cmd[CMD_FIND],
             n_settings);
    $display("checked %0d results, %0d finds that hit, %0d error words",
             checked, found_hits, error_hits);
    if (chk_fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
